// ===== rtl/core/varlen_dpcm_audio_decoder_unit_defines.svh =====
// Assertion macros used by the DPCM decoder back end.
`ifndef VARLEN_DPCM_AUDIO_DECODER_UNIT_DEFINES_SVH
`define VARLEN_DPCM_AUDIO_DECODER_UNIT_DEFINES_SVH

// Clocked immediate-style property check, masked while in reset.
`define VDPCM_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Property that must hold in the cycle after a trigger.
`define VDPCM_ASSERT_NEXT(name, pre, post, msg) \
  `VDPCM_ASSERT(name, (pre) |=> (post), msg)

`endif

// ===== rtl/core/vdpcm_pkg.sv =====
// Types and constants of the DPCM audio decoder.
`default_nettype none

package vdpcm_pkg;

  localparam int unsigned SAMPLE_W    = 16;
  localparam int unsigned CH_OUT_W    = 7;
  localparam int unsigned IDX_W       = 16;
  localparam int unsigned STATUS_W    = 2;
  localparam int unsigned BYTE_CNT_W  = 25;
  localparam int unsigned CFG_IDX_W   = 4;
  localparam int unsigned CFG_DATA_W  = 17;
  localparam int unsigned SPC_MIN     = 16;
  localparam int unsigned Q_DEPTH     = 2;

  localparam logic [BYTE_CNT_W-1:0] BYTE_CNT_MAX = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SPC = 4'd0,
    REG_CHN = 4'd1
  } cfg_reg_e;

  typedef enum logic [2:0] {
    PH_START_LO = 3'd0,
    PH_START_HI = 3'd1,
    PH_DELTA_A  = 3'd2,
    PH_DELTA_B  = 3'd3,
    PH_TRAILING = 3'd4,
    PH_OVERSIZE = 3'd5
  } phase_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_TRUNC = 2'd1,
    ST_OVER  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_ADD   = 2'd1,
    OP_TRUNC = 2'd2,
    OP_OVER  = 2'd3
  } op_kind_e;

  // One decode command from the front to the back.
  typedef struct packed {
    op_kind_e              kind;
    logic [SAMPLE_W-1:0]   value;
    logic [CH_OUT_W-1:0]   ch;
    logic [IDX_W-1:0]      idx;
    logic                  last;
  } op_t;

endpackage

`default_nettype wire

// ===== rtl/core/vdpcm_intf.sv =====
// Handshake interfaces of the DPCM decoder: payload bytes, samples, config writes.
`default_nettype none

interface vdpcm_in_if import vdpcm_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] payload_byte;
  logic       packet_end;

  modport source (output valid, output payload_byte, output packet_end, input ready);
  modport sink   (input valid, input payload_byte, input packet_end, output ready);
endinterface

interface vdpcm_out_if import vdpcm_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample_q15;
  logic [CH_OUT_W-1:0]        channel_index;
  logic [IDX_W-1:0]           sample_index;
  logic                       last_sample;
  logic [STATUS_W-1:0]        status_code;

  modport source (output valid, output sample_q15, output channel_index,
                  output sample_index, output last_sample, output status_code,
                  input ready);
  modport sink   (input valid, input sample_q15, input channel_index,
                  input sample_index, input last_sample, input status_code,
                  output ready);
endinterface

interface vdpcm_cfg_if import vdpcm_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/vdpcm_front.sv =====
// Front end: config registers, byte parsing, packet counters, command issue.
`default_nettype none

module vdpcm_front
  import vdpcm_pkg::*;
#(
  parameter int unsigned MAX_CHANNELS = 128,
  parameter int unsigned MAX_SAMPLES  = 65536
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  vdpcm_in_if.sink       byte_i,
  vdpcm_cfg_if.sink      cfg_i,
  output      logic      push_valid_o,
  input  wire logic      push_ready_i,
  output      op_t       push_op_o
);

  localparam int unsigned CH_W    = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int unsigned CHN_W   = $clog2(MAX_CHANNELS + 1);
  localparam int unsigned SMP_W   = $clog2(MAX_SAMPLES);
  localparam int unsigned SPC_W   = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned BOUND_W = SPC_W + CHN_W + 1;

  logic [SPC_W-1:0]      spc_lim_q, spc_lim_d;
  logic [CHN_W-1:0]      chn_lim_q, chn_lim_d;
  logic [BOUND_W-1:0]    bound_q;

  phase_e                phase_q, phase_d;
  logic [7:0]            held_q, held_d;
  logic [CH_W-1:0]       ch_q, ch_d;
  logic [SMP_W-1:0]      smp_q, smp_d;
  logic [BYTE_CNT_W-1:0] bytes_q, bytes_d;

  logic                  accept;
  logic                  emit;
  logic                  end_of_chan;
  logic                  final_smp;
  logic [7:0]            b;

  assign accept      = byte_i.valid && push_ready_i;
  assign byte_i.ready = push_ready_i;
  assign cfg_i.ready  = 1'b1;
  assign b            = byte_i.payload_byte;

  // Register writes are clamped once here so the datapath sees legal limits.
  always_comb begin
    spc_lim_d = spc_lim_q;
    chn_lim_d = chn_lim_q;
    if (cfg_i.valid) begin
      if (cfg_i.index == REG_SPC) begin
        if (32'(cfg_i.data) < SPC_MIN) begin
          spc_lim_d = SPC_W'(SPC_MIN);
        end else if (32'(cfg_i.data) > MAX_SAMPLES) begin
          spc_lim_d = SPC_W'(MAX_SAMPLES);
        end else begin
          spc_lim_d = SPC_W'(cfg_i.data);
        end
      end else if (cfg_i.index == REG_CHN) begin
        if (cfg_i.data[7:0] == 8'd0) begin
          chn_lim_d = CHN_W'(1);
        end else if (32'(cfg_i.data[7:0]) > MAX_CHANNELS) begin
          chn_lim_d = CHN_W'(MAX_CHANNELS);
        end else begin
          chn_lim_d = CHN_W'(cfg_i.data[7:0]);
        end
      end
    end
  end

  // bound is taken from the next limits, so it changes at the same edge
  // as they do and the following byte already sees it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spc_lim_q <= SPC_W'(SPC_MIN);
      chn_lim_q <= CHN_W'(1);
      bound_q   <= BOUND_W'(2 * SPC_MIN);
    end else begin
      spc_lim_q <= spc_lim_d;
      chn_lim_q <= chn_lim_d;
      bound_q   <= BOUND_W'({spc_lim_d, 1'b0}) * BOUND_W'(chn_lim_d);
    end
  end

  assign end_of_chan = SPC_W'(smp_q) >= (spc_lim_q - SPC_W'(1));
  assign final_smp   = end_of_chan && (CHN_W'(ch_q) >= (chn_lim_q - CHN_W'(1)));

  always_comb begin
    phase_d   = phase_q;
    held_d    = held_q;
    ch_d      = ch_q;
    smp_d     = smp_q;
    bytes_d   = bytes_q;
    emit      = 1'b0;
    push_valid_o = 1'b0;
    push_op_o = '{kind: OP_LOAD, value: '0, ch: '0, idx: '0, last: 1'b0};

    if (phase_q != PH_OVERSIZE && bytes_q != BYTE_CNT_MAX) begin
      bytes_d = bytes_q + 1'b1;
    end

    case (phase_q)
      PH_START_LO: begin
        held_d  = b;
        phase_d = PH_START_HI;
      end
      PH_START_HI: begin
        emit            = 1'b1;
        push_op_o.kind  = OP_LOAD;
        push_op_o.value = {b, held_q};
      end
      PH_DELTA_A: begin
        if (b[7]) begin
          held_d  = {1'b0, b[6:0]};
          phase_d = PH_DELTA_B;
        end else begin
          emit            = 1'b1;
          push_op_o.kind  = OP_ADD;
          push_op_o.value = {{9{b[6]}}, b[6:0]};
        end
      end
      PH_DELTA_B: begin
        // second byte carries delta bits 14..7, bit 14 is the sign
        emit            = 1'b1;
        push_op_o.kind  = OP_ADD;
        push_op_o.value = {b[7], b, held_q[6:0]};
      end
      PH_TRAILING: begin
        if (32'(bytes_d) > 32'(bound_q)) begin
          push_valid_o   = 1'b1;
          push_op_o.kind = OP_OVER;
          phase_d        = PH_OVERSIZE;
        end
      end
      default: begin
        phase_d = PH_OVERSIZE;
      end
    endcase

    if (emit) begin
      push_valid_o   = 1'b1;
      push_op_o.ch   = CH_OUT_W'(ch_q);
      push_op_o.idx  = IDX_W'(smp_q);
      push_op_o.last = final_smp;
      if (final_smp) begin
        phase_d = PH_TRAILING;
      end else if (end_of_chan) begin
        smp_d   = '0;
        ch_d    = ch_q + 1'b1;
        phase_d = PH_START_LO;
      end else begin
        smp_d   = smp_q + 1'b1;
        phase_d = PH_DELTA_A;
      end
    end

    if (byte_i.packet_end) begin
      // samples still missing: report the first one that never came
      if (phase_d == PH_START_LO || phase_d == PH_START_HI ||
          phase_d == PH_DELTA_A || phase_d == PH_DELTA_B) begin
        push_valid_o = 1'b1;
        push_op_o    = '{kind: OP_TRUNC, value: '0, ch: CH_OUT_W'(ch_d),
                         idx: IDX_W'(smp_d), last: 1'b0};
      end
      phase_d = PH_START_LO;
      held_d  = '0;
      ch_d    = '0;
      smp_d   = '0;
      bytes_d = '0;
    end

    if (!byte_i.valid) begin
      push_valid_o = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_START_LO;
      held_q  <= '0;
      ch_q    <= '0;
      smp_q   <= '0;
      bytes_q <= '0;
    end else if (accept) begin
      phase_q <= phase_d;
      held_q  <= held_d;
      ch_q    <= ch_d;
      smp_q   <= smp_d;
      bytes_q <= bytes_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/vdpcm_queue.sv =====
// Two-entry command queue between decoder front and back.
`default_nettype none

module vdpcm_queue
  import vdpcm_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_valid_i,
  output      logic push_ready_o,
  input  wire op_t  push_op_i,
  output      logic pop_valid_o,
  input  wire logic pop_ready_i,
  output      op_t  pop_op_o
);

  localparam int unsigned PTR_W = $clog2(Q_DEPTH);
  localparam int unsigned CNT_W = $clog2(Q_DEPTH + 1);

  op_t              mem_q [Q_DEPTH];
  logic [PTR_W-1:0] wr_q, rd_q;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             push, pop;

  assign push_ready_o = cnt_q != CNT_W'(Q_DEPTH);
  assign pop_valid_o  = cnt_q != '0;
  assign pop_op_o     = mem_q[rd_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    cnt_d = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push) begin
        wr_q <= (32'(wr_q) == Q_DEPTH - 1) ? '0 : wr_q + 1'b1;
      end
      if (pop) begin
        rd_q <= (32'(rd_q) == Q_DEPTH - 1) ? '0 : rd_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= push_op_i;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/vdpcm_back.sv =====
// Back end: running sample accumulator and registered result stage.
`default_nettype none

`include "varlen_dpcm_audio_decoder_unit_defines.svh"

module vdpcm_back
  import vdpcm_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       pop_valid_i,
  output      logic       pop_ready_o,
  input  wire op_t        pop_op_i,
  vdpcm_out_if.source     smp_o
);

  logic [SAMPLE_W-1:0] rv_q, rv_d;
  logic [SAMPLE_W-1:0] smp_d;
  status_e             status_d;
  logic                pop_fire;

  logic                out_valid_q;
  logic [SAMPLE_W-1:0] out_smp_q;
  logic [CH_OUT_W-1:0] out_ch_q;
  logic [IDX_W-1:0]    out_idx_q;
  logic                out_last_q;
  status_e             out_status_q;

  logic                load_fire;
  logic                status_out;
  logic                last_out;

  assign pop_ready_o = !out_valid_q || smp_o.ready;
  assign pop_fire    = pop_valid_i && pop_ready_o;

  always_comb begin
    rv_d     = rv_q;
    smp_d    = '0;
    status_d = ST_OK;
    case (pop_op_i.kind)
      OP_LOAD: begin
        rv_d  = pop_op_i.value;
        smp_d = pop_op_i.value;
      end
      OP_ADD: begin
        rv_d  = rv_q + pop_op_i.value;
        smp_d = rv_q + pop_op_i.value;
      end
      OP_TRUNC: status_d = ST_TRUNC;
      OP_OVER:  status_d = ST_OVER;
      default:  status_d = ST_OK;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rv_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_fire) begin
        rv_q <= rv_d;
      end
      if (pop_ready_o) begin
        out_valid_q <= pop_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_fire) begin
      out_smp_q    <= smp_d;
      out_ch_q     <= pop_op_i.ch;
      out_idx_q    <= pop_op_i.idx;
      out_last_q   <= pop_op_i.last;
      out_status_q <= status_d;
    end
  end

  assign smp_o.valid         = out_valid_q;
  assign smp_o.sample_q15    = out_smp_q;
  assign smp_o.channel_index = out_ch_q;
  assign smp_o.sample_index  = out_idx_q;
  assign smp_o.last_sample   = out_last_q;
  assign smp_o.status_code   = out_status_q;

  assign load_fire  = pop_fire && (pop_op_i.kind == OP_LOAD);
  assign status_out = out_valid_q && (out_status_q != ST_OK);
  assign last_out   = out_valid_q && out_last_q;

  `VDPCM_ASSERT_NEXT(a_load_sets_value, load_fire, rv_q == $past(pop_op_i.value), "start not loaded")
  `VDPCM_ASSERT(a_status_zero_sample, status_out |-> (out_smp_q == '0), "nonzero status sample")
  `VDPCM_ASSERT(a_last_is_sample, last_out |-> (out_status_q == ST_OK), "last flag on status")

endmodule

`default_nettype wire

// ===== rtl/core/varlen_dpcm_audio_decoder_unit.sv =====
// Top level of the variable-length DPCM audio packet decoder.
// Throughput: one payload byte per cycle, sustained, with the output side ready.
// Path: a result reaches smp_o through a queue entry, written at the byte_i transfer that
//   caused it, and then the output register of the back end.
// Reset: rst_ni is asynchronous, active low; clears decode state, queue and output
//   valid; samples_per_channel returns to 16 and channel_count to 1.
`default_nettype none

module varlen_dpcm_audio_decoder_unit
  import vdpcm_pkg::*;
#(
  parameter int unsigned MAX_CHANNELS = 128,
  parameter int unsigned MAX_SAMPLES  = 65536
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  vdpcm_in_if.sink    byte_i,
  vdpcm_cfg_if.sink   cfg_i,
  vdpcm_out_if.source smp_o
);

  // Front to queue: one command per byte that yields a result.
  logic push_valid, push_ready;
  op_t  push_op;

  // Queue to back.
  logic pop_valid, pop_ready;
  op_t  pop_op;

  // Front end: owns the config registers (clamped on write), the parse phase,
  // channel/sample/byte counters and the truncation and oversize checks. It
  // stalls byte_i only when the queue is full.
  vdpcm_front #(
    .MAX_CHANNELS (MAX_CHANNELS),
    .MAX_SAMPLES  (MAX_SAMPLES)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_i       (byte_i),
    .cfg_i        (cfg_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_op_o    (push_op)
  );

  // Two entries decouple the output stall from byte intake: a waiting result
  // does not block the next byte transfer until both entries are taken.
  vdpcm_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_op_i    (push_op),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_op_o     (pop_op)
  );

  // Back end: 16-bit wrapping accumulator and the registered result stage.
  vdpcm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_op_i    (pop_op),
    .smp_o       (smp_o)
  );

endmodule

`default_nettype wire
